// ===== hw/rtl/ucr_pkg.sv =====
// Package for the UTF-8 character reframer.
// Holds the shared widths, byte-class constants, pending-state type and lead decoder.
// No dependencies.
package ucr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PEND_DEPTH = 3;
  localparam int unsigned CHAR_W     = 32;
  localparam int unsigned LEN_W      = 3;
  localparam int unsigned CNT_W      = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  // Byte classes.
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] ASCII_MASK = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;

  // Character lengths announced by a lead byte.
  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THR  = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

  // Control part of the pending state; cnt of zero means idle.
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [LEN_W-1:0] exp_len;
  } ucr_ctrl_t;

  // One finished character.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CHAR_W-1:0] bytes;
  } ucr_char_t;

  // Length announced by a byte taken as a lead; LEN_NONE if it is no lead.
  function automatic logic [LEN_W-1:0] lead_len(input logic [7:0] b);
    logic [LEN_W-1:0] n;
    if ((b & ASCII_MASK) == 8'h00) begin
      n = LEN_ONE;
    end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      n = LEN_TWO;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      n = LEN_THR;
    end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
      n = LEN_FOUR;
    end else begin
      n = LEN_NONE;
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/utf8_char_reframer.sv =====
// Top level of the UTF-8 character reframer.
// Depends on ucr_pkg, ucr_step and ucr_out_stage.
//
// Takes one byte per cycle and emits each complete UTF-8 character as one item of
// up to four bytes, lead byte lowest, with its length; malformed leads and cut-off
// sequences are dropped without a result. A byte is taken every cycle while the
// result register is empty or being drained; the character is registered and
// appears in the cycle after its last byte is taken. The pending state, control
// register and byte store, is updated by one short decode step per byte.
module utf8_char_reframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // char_bytes[31:0], char_len[34:32]
);
  import ucr_pkg::*;

  ucr_ctrl_t                      ctrl_r, ctrl_nxt;
  logic [PEND_DEPTH-1:0][7:0]     pend_r;
  logic [PEND_DEPTH-1:0]          pend_we;
  logic                           emit;
  ucr_char_t                      char_res;
  logic                           free;
  logic                           in_fire;

  assign in_tready = free;
  assign in_fire   = in_tvalid && in_tready;

  ucr_step u_step (
    .ctrl_i    (ctrl_r),
    .pend_i    (pend_r),
    .byte_i    (in_tdata),
    .ctrl_o    (ctrl_nxt),
    .pend_we_o (pend_we),
    .emit_o    (emit),
    .char_o    (char_res)
  );

  // Pending control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else if (in_fire) begin
      ctrl_r <= ctrl_nxt;
    end
  end

  // Pending byte store; entries are read only after being written.
  always_ff @(posedge clk) begin
    for (int i = 0; i < PEND_DEPTH; i++) begin
      if (in_fire && pend_we[i]) begin
        pend_r[i] <= in_tdata;
      end
    end
  end

  ucr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (in_fire && emit),
    .char_i     (char_res),
    .free_o     (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== hw/rtl/ucr_step.sv =====
// Next-state and result logic of the reframer for one incoming byte.
// Depends on ucr_pkg.
module ucr_step (
  input  ucr_pkg::ucr_ctrl_t                   ctrl_i,
  input  logic [ucr_pkg::PEND_DEPTH-1:0][7:0]  pend_i,
  input  logic [7:0]                           byte_i,
  output ucr_pkg::ucr_ctrl_t                   ctrl_o,
  output logic [ucr_pkg::PEND_DEPTH-1:0]       pend_we_o,
  output logic                                 emit_o,
  output ucr_pkg::ucr_char_t                   char_o
);
  import ucr_pkg::*;

  logic             is_cont;
  logic             busy;
  logic [LEN_W-1:0] have;
  logic [LEN_W-1:0] n;
  logic [CHAR_W-1:0] word;

  assign is_cont = (byte_i & CONT_MASK) == CONT_TAG;
  assign busy    = ctrl_i.cnt != '0;
  assign have    = {1'b0, ctrl_i.cnt} + LEN_ONE;
  assign n       = lead_len(byte_i);

  // Assemble the finished word: held bytes below, the new byte at lane cnt, zeros above.
  always_comb begin
    word = '0;
    for (int k = 0; k < PEND_DEPTH; k++) begin
      if (k < int'(ctrl_i.cnt)) begin
        word[k*8 +: 8] = pend_i[k];
      end else if (k == int'(ctrl_i.cnt)) begin
        word[k*8 +: 8] = byte_i;
      end
    end
    if (ctrl_i.cnt == CNT_W'(PEND_DEPTH)) begin
      word[PEND_DEPTH*8 +: 8] = byte_i;
    end
  end

  // Continue, complete, or restart on the byte as a fresh lead.
  always_comb begin
    ctrl_o    = ctrl_i;
    pend_we_o = '0;
    emit_o    = 1'b0;
    char_o.bytes = word;
    char_o.len   = have;
    if (busy && is_cont) begin
      if (have >= ctrl_i.exp_len) begin
        emit_o = 1'b1;
        ctrl_o = '0;
      end else begin
        for (int i = 0; i < PEND_DEPTH; i++) begin
          pend_we_o[i] = (int'(ctrl_i.cnt) == i);
        end
        ctrl_o.cnt = ctrl_i.cnt + CNT_W'(1);
      end
    end else begin
      ctrl_o = '0;
      if (n == LEN_ONE) begin
        emit_o       = 1'b1;
        char_o.bytes = {{(CHAR_W-8){1'b0}}, byte_i};
        char_o.len   = LEN_ONE;
      end else if (n != LEN_NONE) begin
        pend_we_o[0]   = 1'b1;
        ctrl_o.cnt     = CNT_W'(1);
        ctrl_o.exp_len = n;
      end
    end
  end

endmodule

// ===== hw/rtl/ucr_out_stage.sv =====
// Result register of the reframer with the output handshake.
// Depends on ucr_pkg.
module ucr_out_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load_i,
  input  ucr_pkg::ucr_char_t                  char_i,
  output logic                                free_o,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ucr_pkg::OUT_TDATA_W-1:0]     out_tdata  // char_bytes[31:0], char_len[34:32]
);
  import ucr_pkg::*;

  logic      valid_r, valid_nxt;
  ucr_char_t char_r;

  // The register can take a new result when empty or being drained this cycle.
  assign free_o = !valid_r || out_tready;

  always_comb begin
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load_i) begin
      char_r <= char_i;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-CHAR_W-LEN_W){1'b0}}, char_r.len, char_r.bytes};

endmodule

// ===== hw/rtl/ucr_checker.sv =====
// Port-level checks on the UTF-8 character reframer's result channel.
// Depends on nothing but the top level's ports; bound to utf8_char_reframer below.
module ucr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  // A stalled result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Length is one to four and padding bits are zero.
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[34:32] == 3'd1 || out_tdata[34:32] == 3'd2 ||
                    out_tdata[34:32] == 3'd3 || out_tdata[34:32] == 3'd4) &&
                   out_tdata[39:35] == 5'd0)
    else $error("bad character length");

  // A single-byte character is ASCII with empty upper lanes.
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:32] == 3'd1 |-> !out_tdata[7] && out_tdata[31:8] == 24'd0)
    else $error("bad single-byte character");

  // A two-byte character has a two-byte lead and one continuation byte.
  a_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34:32] == 3'd2 |->
      out_tdata[7:5] == 3'b110 && out_tdata[15:14] == 2'b10 && out_tdata[31:16] == 16'd0)
    else $error("bad two-byte character");

  // An ASCII byte taken while the result register is free shows up next cycle.
  a_ascii_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tdata[7] |=>
      out_tvalid && out_tdata[7:0] == $past(in_tdata) && out_tdata[34:32] == 3'd1)
    else $error("ASCII byte not passed through");

endmodule

bind utf8_char_reframer ucr_checker u_ucr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
